// ===== rtl/assert_macros.svh =====
// assertion macros for the window z-order hit tester
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define WZO_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wzo assertion failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define WZO_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wzo assertion failed");

`endif

// ===== rtl/wzo_pkg.sv =====
// types and codes shared by the window z-order hit tester
package wzo_pkg;

  typedef enum logic [2:0] {
    CMD_CREATE = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_MOVE   = 3'd2,
    CMD_RESIZE = 3'd3,
    CMD_OPEN   = 3'd4,
    CMD_CLOSE  = 3'd5,
    CMD_CLICK  = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_WINDOW = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    logic        [2:0]  command;
    logic        [15:0] window_id;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic        [14:0] size_w;
    logic        [14:0] size_h;
  } in_item_t;

  typedef struct packed {
    logic [15:0] result_id;
    logic        hit;
    logic [1:0]  status;
  } out_item_t;

  // control broadcast to every cell
  typedef struct packed {
    logic       capture;
    logic       exec;
    logic [2:0] command;
    logic       any_hit;
  } cell_ctl_t;

endpackage

// ===== rtl/wzo_cell.sv =====
// one slot of the z-ordered window stack with its compare and shift logic
module wzo_cell #(
  parameter int COORD_BITS = 16,
  localparam int SLOT_W = 2 * COORD_BITS + 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wzo_pkg::cell_ctl_t  ctl_i,
  input  wzo_pkg::in_item_t   item_i,
  input  logic                bottom_i,
  input  logic [SLOT_W-1:0]   dn_slot_i,
  input  logic [SLOT_W-1:0]   up_slot_i,
  input  logic [SLOT_W-1:0]   tgt_slot_i,
  input  logic                below_i,
  input  logic                above_i,
  output logic                below_o,
  output logic                above_o,
  output logic                sel_o,
  output logic [SLOT_W-1:0]   slot_o
);
  import wzo_pkg::*;

  localparam int CW = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;

  logic [SLOT_W-1:1] data_q, data_d;
  logic              used_q, used_d;
  logic              hit_q;
  logic              hit_d;

  logic signed [COORD_BITS-1:0] x_s, y_s;
  logic        [14:0]           w_s, h_s;
  logic        [15:0]           id_s;
  logic signed [CW-1:0]         px_e, py_e, x_e, y_e, xl_e, yl_e;
  logic                         in_box;
  logic                         is_top;
  logic                         at_or_below;
  logic                         load_up, load_dn, load_tgt;

  assign slot_o = {data_q, used_q};
  assign x_s    = data_q[SLOT_W-1 -: COORD_BITS];
  assign y_s    = data_q[SLOT_W-1-COORD_BITS -: COORD_BITS];
  assign w_s    = data_q[47:33];
  assign h_s    = data_q[32:18];
  assign id_s   = data_q[17:2];

  // exact half-open containment, wide enough that nothing wraps
  assign px_e   = $signed({{(CW-16){item_i.pos_x[15]}}, item_i.pos_x});
  assign py_e   = $signed({{(CW-16){item_i.pos_y[15]}}, item_i.pos_y});
  assign x_e    = $signed({{(CW-COORD_BITS){x_s[COORD_BITS-1]}}, x_s});
  assign y_e    = $signed({{(CW-COORD_BITS){y_s[COORD_BITS-1]}}, y_s});
  assign xl_e   = x_e + $signed({{(CW-15){1'b0}}, w_s});
  assign yl_e   = y_e + $signed({{(CW-15){1'b0}}, h_s});
  assign in_box = (px_e >= x_e) && (px_e < xl_e) && (py_e >= y_e) && (py_e < yl_e);

  assign hit_d = used_q &&
                 ((item_i.command == CMD_CLICK) ? in_box : (id_s == item_i.window_id));

  // priority chains: any hit below this cell and any hit above it
  assign below_o = below_i | hit_q;
  assign above_o = above_i | hit_q;
  // clicks take the topmost hit, id lookups the bottom-most
  assign sel_o   = hit_q && ((ctl_i.command == CMD_CLICK) ? !above_i : !below_i);

  assign is_top  = used_q && !up_slot_i[0];

  always_comb begin
    load_up     = 1'b0;
    load_dn     = 1'b0;
    load_tgt    = 1'b0;
    at_or_below = below_i | hit_q;
    if (ctl_i.exec) begin
      case (ctl_i.command)
        CMD_CREATE: begin
          load_tgt = !used_q && dn_slot_i[0];
        end
        CMD_DELETE: begin
          load_up = ctl_i.any_hit && used_q && at_or_below;
        end
        CMD_MOVE, CMD_RESIZE, CMD_OPEN: begin
          if (ctl_i.any_hit && used_q && at_or_below) begin
            load_tgt = is_top;
            load_up  = !is_top;
          end
        end
        CMD_CLOSE: begin
          if (ctl_i.any_hit && used_q && !below_i) begin
            load_tgt = bottom_i;
            load_dn  = !bottom_i;
          end
        end
        CMD_CLICK: begin
          if (ctl_i.any_hit && used_q && !above_i) begin
            load_tgt = is_top;
            load_up  = !is_top;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    data_d = data_q;
    used_d = used_q;
    if (load_tgt) begin
      data_d = tgt_slot_i[SLOT_W-1:1];
      used_d = 1'b1;
    end else if (load_up) begin
      data_d = up_slot_i[SLOT_W-1:1];
      used_d = up_slot_i[0];
    end else if (load_dn) begin
      data_d = dn_slot_i[SLOT_W-1:1];
      used_d = dn_slot_i[0];
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      hit_q  <= 1'b0;
    end else begin
      used_q <= used_d;
      if (ctl_i.capture) begin
        hit_q <= hit_d;
      end
    end
  end

endmodule

// ===== rtl/window_z_order_hit_tester.sv =====
// window z-order hit tester: a row of cells each holding one window, bottom in cell 0.
// In the transfer cycle every cell compares the command against its own window (id
// match, or half-open point containment for a click) and stores a hit bit; in the
// next cycle a ripple chain through the cells picks the bottom-most id match or the
// topmost click hit, and each cell in one step either keeps its window, takes its upper
// or lower neighbor's, or takes the selected window in its updated form or a new window
// from a create. The result is written into the output register at the end of that
// cycle, and out_valid_o follows from exec_q through the out_valid_q register. The
// input stalls while exec_q is high and while a result waits stalled in the output
// register, so a new command is taken only after the last one has executed. The compare
// stage is followed by the select-and-shift stage with one command in flight; the hit
// chain across all MAX_WINDOWS cells fills the second stage.
// Windows are kept packed from cell 0 up; a create on a full row reports table full and
// hands out no id, an unknown id reports no such window and leaves the stack alone.
`include "assert_macros.svh"

module window_z_order_hit_tester #(
  parameter int MAX_WINDOWS = 16,
  parameter int COORD_BITS  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  wzo_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output wzo_pkg::out_item_t out_data_o
);
  import wzo_pkg::*;

  localparam int SLOT_W = 2 * COORD_BITS + 48;
  localparam int SUM_W  = ((COORD_BITS > 16) ? COORD_BITS : 16) + 1;
  localparam logic signed [SUM_W-1:0] COORD_HI = SUM_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] COORD_LO = SUM_W'(-(64'sd1 <<< (COORD_BITS - 1)));

  // clamp a wide sum into the stored coordinate range
  function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
    logic signed [COORD_BITS-1:0] r;
    if (v > COORD_HI) begin
      r = COORD_HI[COORD_BITS-1:0];
    end else if (v < COORD_LO) begin
      r = COORD_LO[COORD_BITS-1:0];
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

  // handshake and command registers
  logic       in_xfer;
  logic       exec_q;
  in_item_t   item_q;
  logic       out_valid_q;
  out_item_t  out_data_q;
  out_item_t  res_d;
  logic [15:0] next_ident_q;
  logic       create_ok;

  // cell row wiring
  cell_ctl_t                ctl;
  logic [SLOT_W-1:0]        slot_v [MAX_WINDOWS];
  logic [MAX_WINDOWS:0]     below_c;
  logic [MAX_WINDOWS:0]     above_c;
  logic [MAX_WINDOWS-1:0]   sel_vec;
  logic [MAX_WINDOWS-1:0]   used_vec;
  logic                     any_hit;
  logic                     full;

  // selected window and its updated form
  logic [SLOT_W-1:0]            sel_slot;
  logic [SLOT_W-1:0]            tgt_slot;
  logic signed [COORD_BITS-1:0] sx, sy, tx, ty;
  logic [14:0]                  sw, sh, tw, th;
  logic [15:0]                  sid, tid;
  logic                         sop, top_flag;
  logic signed [SUM_W-1:0]      px_e, py_e, sx_e, sy_e;

  // one command in flight; take the next once the output register will be free
  assign in_stall_o = exec_q | (out_valid_q & out_stall_i);
  assign in_xfer    = in_valid_i & ~in_stall_o;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign below_c[0]           = 1'b0;
  assign above_c[MAX_WINDOWS] = 1'b0;
  assign any_hit              = below_c[MAX_WINDOWS];
  assign full                 = used_vec[MAX_WINDOWS-1];
  assign create_ok            = exec_q && (item_q.command == CMD_CREATE) && !full;

  assign ctl.capture = in_xfer;
  assign ctl.exec    = exec_q;
  assign ctl.command = item_q.command;
  assign ctl.any_hit = any_hit;

  for (genvar i = 0; i < MAX_WINDOWS; i++) begin : g_cell
    logic [SLOT_W-1:0] dn_slot;
    logic [SLOT_W-1:0] up_slot;

    // below the bottom counts as occupied so a create into an empty row lands in cell 0
    if (i == 0) begin : g_bottom
      assign dn_slot = SLOT_W'(1);
    end else begin : g_dn
      assign dn_slot = slot_v[i-1];
    end

    if (i == MAX_WINDOWS - 1) begin : g_top
      assign up_slot = '0;
    end else begin : g_up
      assign up_slot = slot_v[i+1];
    end

    wzo_cell #(
      .COORD_BITS (COORD_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .item_i     (in_data_i),
      .bottom_i   (i == 0),
      .dn_slot_i  (dn_slot),
      .up_slot_i  (up_slot),
      .tgt_slot_i (tgt_slot),
      .below_i    (below_c[i]),
      .above_i    (above_c[i+1]),
      .below_o    (below_c[i+1]),
      .above_o    (above_c[i]),
      .sel_o      (sel_vec[i]),
      .slot_o     (slot_v[i])
    );

    assign used_vec[i] = slot_v[i][0];
  end

  // the selection has at most one bit set, so an and-or picks the chosen window
  always_comb begin
    sel_slot = '0;
    for (int i = 0; i < MAX_WINDOWS; i++) begin
      sel_slot = sel_slot | ({SLOT_W{sel_vec[i]}} & slot_v[i]);
    end
  end

  assign sx  = sel_slot[SLOT_W-1 -: COORD_BITS];
  assign sy  = sel_slot[SLOT_W-1-COORD_BITS -: COORD_BITS];
  assign sw  = sel_slot[47:33];
  assign sh  = sel_slot[32:18];
  assign sid = sel_slot[17:2];
  assign sop = sel_slot[1];

  assign px_e = $signed({{(SUM_W-16){item_q.pos_x[15]}}, item_q.pos_x});
  assign py_e = $signed({{(SUM_W-16){item_q.pos_y[15]}}, item_q.pos_y});
  assign sx_e = $signed({{(SUM_W-COORD_BITS){sx[COORD_BITS-1]}}, sx});
  assign sy_e = $signed({{(SUM_W-COORD_BITS){sy[COORD_BITS-1]}}, sy});

  // window written into the cell that receives the selected or new window
  always_comb begin
    tx       = sx;
    ty       = sy;
    tw       = sw;
    th       = sh;
    tid      = sid;
    top_flag = sop;
    case (item_q.command)
      CMD_CREATE: begin
        tx       = sat_coord(px_e);
        ty       = sat_coord(py_e);
        tw       = item_q.size_w;
        th       = item_q.size_h;
        tid      = next_ident_q;
        top_flag = 1'b1;
      end
      CMD_MOVE: begin
        tx = sat_coord(sx_e + px_e);
        ty = sat_coord(sy_e + py_e);
      end
      CMD_RESIZE: begin
        tw = item_q.size_w;
        th = item_q.size_h;
      end
      CMD_OPEN: begin
        top_flag = 1'b1;
      end
      CMD_CLOSE: begin
        top_flag = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign tgt_slot = {tx, ty, tw, th, tid, top_flag, 1'b1};

  // result of the command being executed
  always_comb begin
    res_d = '0;
    case (item_q.command)
      CMD_CREATE: begin
        if (full) begin
          res_d.status = ST_FULL;
        end else begin
          res_d.result_id = next_ident_q;
        end
      end
      CMD_DELETE, CMD_MOVE, CMD_RESIZE, CMD_OPEN, CMD_CLOSE: begin
        if (!any_hit) begin
          res_d.status = ST_NO_WINDOW;
        end
      end
      CMD_CLICK: begin
        if (any_hit) begin
          res_d.result_id = sid;
          res_d.hit       = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= in_data_i;
    end
    if (exec_q) begin
      out_data_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exec_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      next_ident_q <= '0;
    end else begin
      exec_q <= in_xfer;
      if (exec_q) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      // ids wrap at 16 bits and are only spent on a successful create
      if (create_ok) begin
        next_ident_q <= next_ident_q + 16'd1;
      end
    end
  end

  // occupied cells stay packed from the bottom
  `WZO_ASSERT_IMP(a_used_packed, 1'b1, ((used_vec >> 1) & ~used_vec) == '0)
  // at most one cell is chosen for a command
  `WZO_ASSERT_IMP(a_sel_onehot, exec_q, $onehot0(sel_vec))
  // every executed command leaves a result in the output register
  `WZO_ASSERT_NXT(a_exec_result, exec_q, out_valid_q)
  // a create on a row with room adds exactly one window
  `WZO_ASSERT_NXT(a_create_grows, create_ok, $countones(used_vec) == $countones($past(used_vec)) + 1)

endmodule
